// ===== design/spfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sensor packet frame checker package
// Shared types and constants of the packet deframer.
// ============================================================================
package spfc_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_DATA_W = 32;

    localparam logic CFG_START_CODE  = 1'b0;
    localparam logic CFG_MODULE_ADDR = 1'b1;

    localparam logic [15:0] START_CODE_RST  = 16'hEF01;
    localparam logic [31:0] MODULE_ADDR_RST = 32'hFFFF_FFFF;

    localparam logic [7:0] TYPE_COMMAND     = 8'h01;
    localparam logic [7:0] TYPE_DATA        = 8'h02;
    localparam logic [7:0] TYPE_ACK         = 8'h07;
    localparam logic [7:0] TYPE_END_OF_DATA = 8'h08;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_CHECKSUM_BAD = 3'd1;
    localparam logic [2:0] ST_ADDRESS_BAD  = 3'd2;
    localparam logic [2:0] ST_TYPE_BAD     = 3'd3;
    localparam logic [2:0] ST_LENGTH_BAD   = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic [2:0] status;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

// ===== design/spfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sensor packet frame checker front end
// Parses each accepted byte against the packet format and produces at most
// one result transaction per byte.
// ============================================================================
module spfc_front #(
    parameter int MAX_PAYLOAD = spfc_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_take,
    input  wire  [7:0]                    i_rx_byte,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_index,
    input  wire  [spfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_res_valid,
    output spfc_pkg::t_result             o_res
);
    import spfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int SUM_W = $clog2(3 * 255 + MAX_PAYLOAD * 255 + 1);
    localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD + 2);

    typedef enum logic [8:0] {
        PH_HUNT1 = 9'b0_0000_0001,
        PH_HUNT2 = 9'b0_0000_0010,
        PH_ADDR  = 9'b0_0000_0100,
        PH_TYPE  = 9'b0_0000_1000,
        PH_LENH  = 9'b0_0001_0000,
        PH_LENL  = 9'b0_0010_0000,
        PH_DATA  = 9'b0_0100_0000,
        PH_CSH   = 9'b0_1000_0000,
        PH_CSL   = 9'b1_0000_0000
    } t_phase;

    logic [15:0]      r_start_code;
    logic [31:0]      r_module_addr;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_target, n_target;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [7:0]       r_csh, n_csh;
    logic             r_addr_bad, n_addr_bad;
    logic             r_type_bad, n_type_bad;

    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  addr_byte;
    logic [15:0] length;
    logic [CNT_W-1:0] cnt_inc;

    assign first_byte  = r_start_code[15:8];
    assign second_byte = r_start_code[7:0];
    assign length      = {r_len_hi, i_rx_byte};
    assign cnt_inc     = r_cnt + CNT_W'(1);

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    addr_byte = r_module_addr[31:24];
            2'd1:    addr_byte = r_module_addr[23:16];
            2'd2:    addr_byte = r_module_addr[15:8];
            default: addr_byte = r_module_addr[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_target   = r_target;
        n_sum      = r_sum;
        n_type     = r_type;
        n_len_hi   = r_len_hi;
        n_csh      = r_csh;
        n_addr_bad = r_addr_bad;
        n_type_bad = r_type_bad;
        o_res_valid         = 1'b0;
        o_res.kind          = KIND_PAYLOAD;
        o_res.payload_byte  = 8'd0;
        o_res.packet_type   = r_type;
        o_res.status        = ST_OK;
        o_res.last          = 1'b0;
        case (r_phase)
            PH_HUNT2: begin
                if (i_rx_byte == second_byte) begin
                    n_phase    = PH_ADDR;
                    n_cnt      = '0;
                    n_addr_bad = 1'b0;
                    n_type_bad = 1'b0;
                    n_sum      = '0;
                    n_type     = 8'd0;
                    n_len_hi   = 8'd0;
                    n_csh      = 8'd0;
                end else if (i_rx_byte != first_byte) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_ADDR: begin
                if (addr_byte != i_rx_byte) begin
                    n_addr_bad = 1'b1;
                end
                if (r_cnt[1:0] == 2'd3) begin
                    n_phase = PH_TYPE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_TYPE: begin
                n_type     = i_rx_byte;
                n_type_bad = !(i_rx_byte inside {TYPE_COMMAND, TYPE_DATA, TYPE_ACK,
                                                 TYPE_END_OF_DATA});
                n_sum      = SUM_W'(i_rx_byte);
                n_phase    = PH_LENH;
            end
            PH_LENH: begin
                n_len_hi = i_rx_byte;
                n_sum    = r_sum + SUM_W'(i_rx_byte);
                n_phase  = PH_LENL;
            end
            PH_LENL: begin
                n_sum = r_sum + SUM_W'(i_rx_byte);
                if (length < 16'd2 || length > LEN_MAX) begin
                    n_phase      = PH_HUNT1;
                    o_res_valid  = 1'b1;
                    o_res.kind   = KIND_STATUS;
                    o_res.status = ST_LENGTH_BAD;
                    o_res.last   = 1'b1;
                end else begin
                    n_cnt    = '0;
                    n_target = CNT_W'(length - 16'd2);
                    n_phase  = (length == 16'd2) ? PH_CSH : PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum = r_sum + SUM_W'(i_rx_byte);
                n_cnt = cnt_inc;
                if (cnt_inc >= r_target) begin
                    n_phase = PH_CSH;
                end
                o_res_valid        = 1'b1;
                o_res.payload_byte = i_rx_byte;
            end
            PH_CSH: begin
                n_csh   = i_rx_byte;
                n_phase = PH_CSL;
            end
            PH_CSL: begin
                n_phase     = PH_HUNT1;
                o_res_valid = 1'b1;
                o_res.kind  = KIND_STATUS;
                o_res.last  = 1'b1;
                if (32'(r_sum) != {16'd0, r_csh, i_rx_byte}) begin
                    o_res.status = ST_CHECKSUM_BAD;
                end else if (r_addr_bad) begin
                    o_res.status = ST_ADDRESS_BAD;
                end else if (r_type_bad) begin
                    o_res.status = ST_TYPE_BAD;
                end else begin
                    o_res.status = ST_OK;
                end
            end
            default: begin
                n_phase = (i_rx_byte == first_byte) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
        if (!i_take) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code  <= START_CODE_RST;
            r_module_addr <= MODULE_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_CODE:  r_start_code  <= i_cfg_data[15:0];
                CFG_MODULE_ADDR: r_module_addr <= i_cfg_data[31:0];
                default:         r_start_code  <= r_start_code;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT1;
            r_cnt      <= '0;
            r_target   <= '0;
            r_sum      <= '0;
            r_type     <= 8'd0;
            r_len_hi   <= 8'd0;
            r_csh      <= 8'd0;
            r_addr_bad <= 1'b0;
            r_type_bad <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_target   <= n_target;
            r_sum      <= n_sum;
            r_type     <= n_type;
            r_len_hi   <= n_len_hi;
            r_csh      <= n_csh;
            r_addr_bad <= n_addr_bad;
            r_type_bad <= n_type_bad;
        end
    end

endmodule
`default_nettype wire

// ===== design/spfc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sensor packet frame checker result queue
// Short register queue that decouples the parser from the output stage.
// ============================================================================
module spfc_fifo #(
    parameter int DEPTH = spfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_wr,
    input  spfc_pkg::t_result  i_wr_data,
    input  wire                i_rd,
    output spfc_pkg::t_result  o_rd_data,
    output logic               o_full,
    output logic               o_empty
);
    import spfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/spfc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sensor packet frame checker output stage
// Holds the oldest result in an output register and drains the queue into it
// whenever the register is free or being taken.
// ============================================================================
module spfc_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_q_empty,
    input  spfc_pkg::t_result  i_q_data,
    output logic               o_q_rd,
    input  wire                i_pop,
    output logic               o_empty,
    output spfc_pkg::t_result  o_res
);
    import spfc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_res <= i_q_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/sensor_packet_frame_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Sensor packet frame checker
// Deframes a received byte stream: finds the start code, checks the address,
// type, length and 16-bit sum checksum, and passes on payload bytes followed
// by one status transaction per packet.
//
// Input channel: one byte per transaction on i_rx_byte, taken when push is
// high and full is low. Result channel: a result is on the o_ ports while
// empty is low and is taken when pop is high. Configuration registers (start
// code, module address) are written through i_cfg_we, i_cfg_index and
// i_cfg_data with no wait; a write acts on the next byte.
// A byte is parsed in the cycle it is accepted; its result, if any, enters a
// result queue at that edge and moves into the output register whenever that
// register is free or being taken; from then on it is on the result ports.
// The parser state machine takes one byte per cycle while full is low.
// When the receiver stalls, results collect in the queue (QUEUE_DEPTH entries)
// plus the output register; full rises only when the queue has no room left.
// Reset returns the parser to hunting for the first start byte, empties the
// queue and output register, and restores the register reset values.
// ============================================================================
module sensor_packet_frame_checker #(
    parameter int MAX_PAYLOAD = spfc_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = spfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             push,
    output logic                            full,
    input  wire  [7:0]                      i_rx_byte,
    output logic                            empty,
    input  wire                             pop,
    output logic                            o_kind,
    output logic [7:0]                      o_payload_byte,
    output logic [7:0]                      o_packet_type,
    output logic [2:0]                      o_status,
    output logic                            o_last,
    input  wire                             i_cfg_we,
    input  wire                             i_cfg_index,
    input  wire  [spfc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spfc_pkg::*;

    logic    take;
    logic    res_valid;
    t_result res;
    t_result q_data;
    logic    q_full;
    logic    q_empty;
    logic    q_rd;
    t_result out_res;

    assign full = q_full;
    assign take = push && !q_full;

    spfc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    spfc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res),
        .i_rd      (q_rd),
        .o_rd_data (q_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    spfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_packet_type  = out_res.packet_type;
    assign o_status       = out_res.status;
    assign o_last         = out_res.last;

    a_payload_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_PAYLOAD) |-> (o_status == ST_OK && !o_last))
        else $error("payload result carries status or last");

    a_status_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_STATUS) |-> (o_last && o_payload_byte == 8'd0))
        else $error("status result without last or with payload");

    a_status_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= ST_LENGTH_BAD))
        else $error("status code out of range");

    a_full_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full while output register is empty");

endmodule
`default_nettype wire

// ===== tb/sv/sensor_packet_frame_checker_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Sensor packet frame checker testbench
// Feeds framed and broken byte streams into the deframer under several start
// code and module address settings, with random idling on both queue sides
// except in the last setting. A local frame parser predicts every payload and
// status transaction, and a monitor compares each result field with the oldest prediction.
// ============================================================================
module sensor_packet_frame_checker_tb;
    import spfc_pkg::*;

    localparam real CLK_PERIOD     = 12.0;
    localparam int  RESET_CYCLES   = 10;
    localparam int  DRAIN_CYCLES   = 8;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  PHASE_BYTES    = 190;
    localparam int  MAX_PRINTED    = 30;

    typedef enum logic [3:0] {
        FP_SEEK_FIRST,
        FP_SEEK_SECOND,
        FP_ADDRESS,
        FP_TYPE,
        FP_LENGTH_HIGH,
        FP_LENGTH_LOW,
        FP_PAYLOAD,
        FP_CHECKSUM_HIGH,
        FP_CHECKSUM_LOW
    } t_frame_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            i_rx_byte = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_kind;
    logic [7:0]            o_payload_byte;
    logic [7:0]            o_packet_type;
    logic [2:0]            o_status;
    logic                  o_last;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [7:0]   pending_bytes[$];
    t_result      expected_results[$];

    logic [15:0]  cfg_start = START_CODE_RST;
    logic [31:0]  cfg_addr = MODULE_ADDR_RST;

    t_frame_phase fr_phase = FP_SEEK_FIRST;
    logic [8:0]   fr_count = '0;
    logic [16:0]  fr_sum = '0;
    logic [7:0]   fr_type = '0;
    logic [15:0]  fr_len = '0;
    logic [7:0]   fr_cs_high = '0;
    logic         fr_addr_bad = 1'b0;
    logic         fr_type_bad = 1'b0;

    bit           no_idle = 1'b0;
    int           send_gap = 0;
    int           pop_stall = 0;
    int           quiet_cycles = 0;
    int           mismatch_count = 0;
    int           bytes_accepted = 0;
    int           frames_queued = 0;
    int           payload_seen = 0;
    int           status_seen[0:4] = '{default: 0};
    t_result      oldest;

    sensor_packet_frame_checker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_packet_type  (o_packet_type),
        .o_status       (o_status),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic void expect_result(input logic kind, input logic [7:0] pay,
                                          input logic [2:0] st);
        t_result r;
        r.kind         = kind;
        r.payload_byte = pay;
        r.packet_type  = fr_type;
        r.status       = st;
        r.last         = (kind == KIND_STATUS);
        expected_results.push_back(r);
    endfunction

    function automatic void parse_frame_byte(input logic [7:0] b);
        logic [7:0] first_b;
        logic [7:0] second_b;
        logic [2:0] st;
        first_b  = cfg_start[15:8];
        second_b = cfg_start[7:0];
        case (fr_phase)
            FP_SEEK_SECOND: begin
                if (b == second_b) begin
                    fr_phase    = FP_ADDRESS;
                    fr_count    = '0;
                    fr_addr_bad = 1'b0;
                    fr_type_bad = 1'b0;
                    fr_sum      = '0;
                    fr_type     = '0;
                    fr_len      = '0;
                    fr_cs_high  = '0;
                end else if (b != first_b) begin
                    fr_phase = FP_SEEK_FIRST;
                end
            end
            FP_ADDRESS: begin
                if (cfg_addr[8 * (3 - fr_count[1:0]) +: 8] != b) begin
                    fr_addr_bad = 1'b1;
                end
                if (fr_count[1:0] == 2'd3) begin
                    fr_phase = FP_TYPE;
                    fr_count = '0;
                end else begin
                    fr_count = fr_count + 9'd1;
                end
            end
            FP_TYPE: begin
                fr_type     = b;
                fr_type_bad = !(b == TYPE_COMMAND || b == TYPE_DATA ||
                                b == TYPE_ACK || b == TYPE_END_OF_DATA);
                fr_sum      = {9'd0, b};
                fr_phase    = FP_LENGTH_HIGH;
            end
            FP_LENGTH_HIGH: begin
                fr_len   = {b, 8'd0};
                fr_sum   = fr_sum + {9'd0, b};
                fr_phase = FP_LENGTH_LOW;
            end
            FP_LENGTH_LOW: begin
                fr_len[7:0] = b;
                fr_sum      = fr_sum + {9'd0, b};
                if (fr_len < 16'd2 || int'(fr_len) > MAX_PAYLOAD_DEF + 2) begin
                    fr_phase = FP_SEEK_FIRST;
                    expect_result(KIND_STATUS, 8'd0, ST_LENGTH_BAD);
                end else begin
                    fr_count = '0;
                    fr_phase = (fr_len == 16'd2) ? FP_CHECKSUM_HIGH : FP_PAYLOAD;
                end
            end
            FP_PAYLOAD: begin
                fr_sum   = fr_sum + {9'd0, b};
                fr_count = fr_count + 9'd1;
                if ({7'd0, fr_count} >= fr_len - 16'd2) begin
                    fr_phase = FP_CHECKSUM_HIGH;
                end
                expect_result(KIND_PAYLOAD, b, ST_OK);
            end
            FP_CHECKSUM_HIGH: begin
                fr_cs_high = b;
                fr_phase   = FP_CHECKSUM_LOW;
            end
            FP_CHECKSUM_LOW: begin
                if (fr_sum != {1'b0, fr_cs_high, b}) begin
                    st = ST_CHECKSUM_BAD;
                end else if (fr_addr_bad) begin
                    st = ST_ADDRESS_BAD;
                end else if (fr_type_bad) begin
                    st = ST_TYPE_BAD;
                end else begin
                    st = ST_OK;
                end
                fr_phase = FP_SEEK_FIRST;
                expect_result(KIND_STATUS, 8'd0, st);
            end
            default: begin
                fr_phase = (b == first_b) ? FP_SEEK_SECOND : FP_SEEK_FIRST;
            end
        endcase
    endfunction

    // Appends one frame, or one broken frame, to the pending byte stream.
    task automatic queue_random_frame(input bit max_len, input bit all_ones);
        logic [7:0]  first_b;
        logic [7:0]  second_b;
        logic [7:0]  b;
        logic [7:0]  ftype;
        logic [15:0] flen;
        logic [15:0] csum;
        logic [31:0] addr;
        int          shape;
        int          plen;
        int          k;
        int          byte_sum;
        first_b  = cfg_start[15:8];
        second_b = cfg_start[7:0];
        frames_queued++;
        if (!max_len && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                if (b == first_b) begin
                    b = ~b;
                end
                pending_bytes.push_back(b);
            end
        end
        shape = max_len ? 99 : $urandom_range(0, 99);
        pending_bytes.push_back(first_b);
        if (shape < 6) begin
            b = 8'($urandom_range(0, 255));
            if (b == second_b) begin
                b = ~b;
            end
            pending_bytes.push_back(b);
        end else begin
            if (first_b != second_b && $urandom_range(0, 9) == 0) begin
                pending_bytes.push_back(first_b);
            end
            pending_bytes.push_back(second_b);
            addr = cfg_addr;
            if ($urandom_range(0, 7) == 0) begin
                k = $urandom_range(0, 3);
                addr[8 * k +: 8] = addr[8 * k +: 8] ^ 8'($urandom_range(1, 255));
            end
            for (k = 3; k >= 0; k--) begin
                pending_bytes.push_back(addr[8 * k +: 8]);
            end
            case ($urandom_range(0, 5))
                0: ftype = TYPE_COMMAND;
                1: ftype = TYPE_DATA;
                2: ftype = TYPE_ACK;
                3: ftype = TYPE_END_OF_DATA;
                default: ftype = 8'($urandom_range(0, 255));
            endcase
            if (all_ones) begin
                ftype = 8'hFF;
            end
            if (shape < 12) begin
                case ($urandom_range(0, 3))
                    0: flen = 16'($urandom_range(0, 1));
                    1: flen = 16'(MAX_PAYLOAD_DEF + 3);
                    2: flen = 16'hFFFF;
                    default: flen = 16'($urandom_range(MAX_PAYLOAD_DEF + 3, 65535));
                endcase
                pending_bytes.push_back(ftype);
                pending_bytes.push_back(flen[15:8]);
                pending_bytes.push_back(flen[7:0]);
            end else begin
                if (max_len) begin
                    plen = MAX_PAYLOAD_DEF;
                end else if ($urandom_range(0, 7) == 0) begin
                    plen = $urandom_range(13, 40);
                end else begin
                    plen = $urandom_range(0, 12);
                end
                flen = 16'(plen + 2);
                byte_sum = int'(ftype) + int'(flen[15:8]) + int'(flen[7:0]);
                pending_bytes.push_back(ftype);
                pending_bytes.push_back(flen[15:8]);
                pending_bytes.push_back(flen[7:0]);
                for (k = 0; k < plen; k++) begin
                    b = all_ones ? 8'hFF : 8'($urandom_range(0, 255));
                    byte_sum += int'(b);
                    pending_bytes.push_back(b);
                end
                csum = byte_sum[15:0];
                if ($urandom_range(0, 7) == 0) begin
                    csum = csum ^ 16'($urandom_range(1, 65535));
                end
                pending_bytes.push_back(csum[15:8]);
                pending_bytes.push_back(csum[7:0]);
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_START_CODE) begin
            cfg_start = value[15:0];
        end else begin
            cfg_addr = value;
        end
    endtask

    task automatic wait_until_drained();
        while (pending_bytes.size() != 0 || push || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_frame_byte(i_rx_byte);
                pending_bytes.delete(0);
                bytes_accepted++;
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(0, 4);
                push <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                push      <= 1'b1;
                i_rx_byte <= pending_bytes[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    oldest = expected_results.pop_front();
                    if (o_kind != oldest.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  o_kind, oldest.kind));
                    end
                    if (o_payload_byte != oldest.payload_byte) begin
                        report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                                  o_payload_byte, oldest.payload_byte));
                    end
                    if (o_packet_type != oldest.packet_type) begin
                        report_mismatch($sformatf("packet_type %02h, expected %02h",
                                                  o_packet_type, oldest.packet_type));
                    end
                    if (o_status != oldest.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, oldest.status));
                    end
                    if (o_last != oldest.last) begin
                        report_mismatch($sformatf("last %0d, expected %0d",
                                                  o_last, oldest.last));
                    end
                    if (oldest.kind == KIND_PAYLOAD) begin
                        payload_seen++;
                    end else if (oldest.status <= ST_LENGTH_BAD) begin
                        status_seen[oldest.status]++;
                    end
                end
            end
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                pop_stall = $urandom_range(0, 4);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [15:0] start_list[4];
        logic [31:0] addr_list[4];
        int          p;
        start_list = '{16'h0000, 16'hFFFF, 16'hABAB, 16'($urandom_range(0, 65535))};
        addr_list  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bad second start byte, a repeated first start byte, a frame with
        // no payload, and a frame whose length is too short.
        pending_bytes = '{8'hEF, 8'h00,
                          8'hEF, 8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          TYPE_END_OF_DATA, 8'h00, 8'h02, 8'h00, 8'h0A,
                          8'hEF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          TYPE_ACK, 8'h00, 8'h01};

        for (p = 0; p < 4; p++) begin
            wait_until_drained();
            write_reg(CFG_START_CODE, {16'd0, start_list[p]});
            write_reg(CFG_MODULE_ADDR, addr_list[p]);
            no_idle = (p == 3);
            if (p == 0) begin
                queue_random_frame(1'b1, 1'b1);
            end else if (p == 2) begin
                queue_random_frame(1'b1, 1'b0);
            end
            while (pending_bytes.size() < PHASE_BYTES) begin
                queue_random_frame(1'b0, 1'b0);
            end
        end
        wait_until_drained();

        $display("Covered %0d bytes in %0d queued frames over 5 register settings,",
                 bytes_accepted, frames_queued);
        $display("%0d payload results. Status results: ok %0d, checksum %0d, %s%0d, %s%0d, %s%0d.",
                 payload_seen, status_seen[0], status_seen[1],
                 "address ", status_seen[2], "type ", status_seen[3],
                 "length ", status_seen[4]);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/spfc_pkg.sv
design/spfc_front.sv
design/spfc_fifo.sv
design/spfc_back.sv
design/sensor_packet_frame_checker.sv
tb/sv/sensor_packet_frame_checker_tb.sv
